// ===== sv/slid_pkg.sv =====
// Package with shared constants, codes and link types for the sorted list block.
`timescale 1ns / 1ps

package slid_pkg;

    // Number of cells in the chain, and width of the fill counter.
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } slid_cmd_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DELETED  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } slid_status_t;

    // Handed from a cell to its right-hand neighbor.
    typedef struct packed {
        logic                     lt;
        logic signed [DATA_W-1:0] entry;
    } slid_link_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } slid_ctrl_t;

endpackage

// ===== sv/slid_ifs.sv =====
// Channel interfaces for the command and response transfers.
`timescale 1ns / 1ps

interface slid_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface slid_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic signed [31:0] smallest;

    modport source (output valid, output status, output entry_count, output smallest,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input smallest,
                    output ready);
endinterface

// ===== sv/slid_cell.sv =====
// One compare-and-shift cell of the sorted chain.
`timescale 1ns / 1ps

module slid_cell
    import slid_pkg::*;
(
    input  logic                     clk,
    input  slid_ctrl_t               ctrl,
    input  logic                     occ,
    input  slid_link_t               left,
    input  logic signed [DATA_W-1:0] right_entry,
    output slid_link_t               link,
    output logic signed [DATA_W-1:0] entry_next,
    output logic                     hit
);

    logic signed [DATA_W-1:0] entry_reg;
    logic                     lt;

    // Occupied cells holding a value below the command value stay in place.
    assign lt  = occ && (entry_reg < ctrl.value);
    // The first cell at or above the value is where a matching entry must sit.
    assign hit = occ && !lt && left.lt && (entry_reg == ctrl.value);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && !lt)
        begin
            entry_next = left.lt ? ctrl.value : left.entry;
        end
        else if (ctrl.del && !lt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.lt    = lt;
    assign link.entry = entry_reg;

endmodule

// ===== sv/sorted_list_insert_delete.sv =====
// Top level of the sorted list: a chain of cells plus command and response control.
// Latency: a response appears in the cycle after its command transfer.
// Throughput: one command per cycle while the response side keeps taking transfers;
// the whole chain shifts at once, so the cell row never holds back a command.
// Reset clears the entry count and the response valid; cell contents are not cleared,
// since only cells below the entry count are ever read.
`timescale 1ns / 1ps

module sorted_list_insert_delete
    import slid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    slid_req_if.sink  req,
    slid_rsp_if.source rsp
);

    // The fill counter is the only control state of the list itself. A cell
    // counts as occupied when its position is below the counter.
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    logic                     rsp_valid_reg;
    logic [1:0]               status_reg;
    logic [4:0]               entry_count_reg;
    logic signed [DATA_W-1:0] smallest_reg;

    logic                     accept;
    logic                     is_insert;
    logic                     full;
    logic                     found;
    slid_status_t             status_next;
    slid_ctrl_t               ctrl;

    slid_link_t               links [CAPACITY+1];
    logic signed [DATA_W-1:0] entry_next [CAPACITY];
    logic [CAPACITY-1:0]      hits;

    // A new command is taken whenever the response register is empty or is
    // being emptied in this same cycle.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_insert = (req.cmd == CMD_INSERT);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    // At most one cell can flag a match: the first cell not below the value.
    assign found = |hits;

    assign ctrl.ins   = accept && is_insert && !full;
    assign ctrl.del   = accept && !is_insert && found;
    assign ctrl.value = req.value;

    // The left end of the chain acts as if a smaller entry stood there, so an
    // insert that lands at the front takes the new value directly.
    assign links[0].lt    = 1'b1;
    assign links[0].entry = req.value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] right_entry;

        // The last cell has no right-hand neighbor; what it takes on a delete
        // lies beyond the new count and is never read.
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = links[i+1].entry;
        end
        else
        begin : g_mid
            assign right_entry = links[i+2].entry;
        end

        slid_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occ         (CNT_W'(i) < count_reg),
            .left        (links[i]),
            .right_entry (right_entry),
            .link        (links[i+1]),
            .entry_next  (entry_next[i]),
            .hit         (hits[i])
        );
    end

    // Status and count for the command being transferred.
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_INSERTED;
        if (is_insert)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
                count_next  = count_reg + 1'b1;
            end
        end
        else
        begin
            if (found)
            begin
                status_next = ST_DELETED;
                count_next  = count_reg - 1'b1;
            end
            else
            begin
                status_next = ST_NOTFOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload; the smallest value is read from the front cell's
    // next contents so it reflects the list after this command.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            entry_count_reg <= 5'(count_next);
            smallest_reg    <= (count_next != '0) ? entry_next[0] : '0;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.smallest    = smallest_reg;

endmodule

// ===== sv/slid_checker.sv =====
// Port-level checker for the sorted list, bound to the top level.
`timescale 1ns / 1ps

module slid_checker
    import slid_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [4:0]  entry_count,
    input logic signed [31:0] smallest
);

    // A refused insert is only reported when the list holds its full capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_FULL) |-> (entry_count == 5'(CAPACITY)))
        else $error("full status with list not at capacity");

    // An empty list reports zero as its smallest value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && entry_count == 5'd0) |-> (smallest == 32'sd0))
        else $error("empty list reports nonzero smallest");

    // A successful insert always leaves at least one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_INSERTED) |-> (entry_count != 5'd0))
        else $error("insert reported with empty list");

    // Every command transfer yields a response in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("no response after command transfer");

    // A stalled response holds its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status)))
        else $error("stalled response changed");

endmodule

bind sorted_list_insert_delete slid_checker u_slid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .entry_count (rsp.entry_count),
    .smallest    (rsp.smallest)
);

// ===== bench/sorted_list_insert_delete_test.sv =====
// Self-checking bench for the sorted list block: queued command driver, response monitor.
`timescale 1ns / 1ps

module sorted_list_insert_delete_test;
    import slid_pkg::*;

    // The slowest correct run (every command behind a long sender gap and a long
    // receiver stall) stays well below this limit, so it only fires on a hang.
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_COMMANDS = 1700;
    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

    // One command waiting to be driven. When hold_until_idle is set, the
    // driver keeps it back until every earlier response has come out.
    typedef struct {
        slid_cmd_t                op;
        logic signed [DATA_W-1:0] value;
        bit                       hold_until_idle;
    } command_t;

    // What one response transfer must carry.
    typedef struct {
        slid_status_t             status;
        logic [CNT_W-1:0]         entry_count;
        logic signed [DATA_W-1:0] smallest;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    slid_req_if req_ch ();
    slid_rsp_if rsp_ch ();

    sorted_list_insert_delete dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    command_t     queued_commands[$];
    list_result_t expected_results[$];

    // The bench's own copy of the ordered store and its fill level.
    logic signed [DATA_W-1:0] sorted_vals[CAPACITY];
    int                       sorted_fill = 0;

    // Multiset of the values the list will hold once every queued command
    // has gone through; used only to steer stimulus toward hits and fills.
    logic signed [DATA_W-1:0] future_contents[$];

    int error_count = 0;
    int response_count = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int cycle_count = 0;

    int send_gap = 0;
    int send_quiet = 0;
    int recv_stall = 0;
    int recv_quiet = 0;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int draw_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Applies one command to the bench's store and returns the response it
    // must produce. Inserts land after all smaller entries, so equal values
    // stay together; a delete takes out only the first equal entry.
    function automatic list_result_t apply_command(slid_cmd_t op,
                                                   logic signed [DATA_W-1:0] val);
        list_result_t res;
        int pos;
        pos = 0;
        if (op == CMD_INSERT)
        begin
            if (sorted_fill >= CAPACITY)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                while (pos < sorted_fill && sorted_vals[pos] < val)
                    pos++;
                for (int i = sorted_fill; i > pos; i--)
                    sorted_vals[i] = sorted_vals[i-1];
                sorted_vals[pos] = val;
                sorted_fill++;
                res.status = ST_INSERTED;
            end
        end
        else
        begin
            while (pos < sorted_fill && sorted_vals[pos] !== val)
                pos++;
            if (pos >= sorted_fill)
            begin
                res.status = ST_NOTFOUND;
            end
            else
            begin
                for (int i = pos; i + 1 < sorted_fill; i++)
                    sorted_vals[i] = sorted_vals[i+1];
                sorted_fill--;
                res.status = ST_DELETED;
            end
        end
        res.entry_count = CNT_W'(sorted_fill);
        res.smallest = (sorted_fill > 0) ? sorted_vals[0] : '0;
        return res;
    endfunction

    // Queues a command and keeps the stimulus-side multiset in step with it.
    task automatic queue_command(slid_cmd_t op, logic signed [DATA_W-1:0] val,
                                 bit hold);
        command_t c;
        c.op = op;
        c.value = val;
        c.hold_until_idle = hold;
        queued_commands.push_back(c);
        if (op == CMD_INSERT)
        begin
            if (future_contents.size() < CAPACITY)
                future_contents.push_back(val);
        end
        else
        begin
            foreach (future_contents[i])
            begin
                if (future_contents[i] === val)
                begin
                    future_contents.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch on response %0d: %s", $realtime, response_count, what);
    endtask

    // Command driver. A new command is presented only when the channel is
    // free, which is when nothing is shown or the shown one transfers at this
    // edge; valid therefore gets at most one assignment per edge and holds while a shown command waits.
    always @(posedge clk or negedge rst_n)
    begin : command_driver
        command_t head;
        bit       busy;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.cmd <= CMD_INSERT;
            req_ch.value <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            // A command transferring now, a response not yet taken, or an
            // expectation still queued all mean the block is not yet idle.
            busy = req_ch.valid || rsp_ch.valid || expected_results.size() != 0;
            if (send_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (queued_commands.size() != 0
                     && !(queued_commands[0].hold_until_idle && busy))
            begin
                head = queued_commands.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.cmd <= head.op;
                req_ch.value <= head.value;
                // Occasionally a stretch of back-to-back commands.
                if (send_quiet > 0)
                begin
                    send_quiet <= send_quiet - 1;
                end
                else if ($urandom_range(0, 39) == 0)
                begin
                    send_quiet <= $urandom_range(30, 60);
                end
                else
                begin
                    send_gap <= draw_idle();
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response ready. Stalls are drawn after transfers and, more rarely,
    // while waiting, so they land on every phase of the block's work.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            rsp_ch.ready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end
        else if (recv_quiet > 0)
        begin
            rsp_ch.ready <= 1'b1;
            if (rsp_ch.valid && rsp_ch.ready)
                recv_quiet <= recv_quiet - 1;
        end
        else if ((rsp_ch.valid && rsp_ch.ready) || $urandom_range(0, 15) == 0)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                rsp_ch.ready <= 1'b1;
                recv_quiet <= $urandom_range(30, 60);
            end
            else
            begin
                recv_stall <= draw_idle();
                rsp_ch.ready <= 1'b1;
            end
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Monitor. Command transfers are predicted before response transfers
    // are checked, so even a same-edge response would find its expectation.
    always @(posedge clk)
    begin : response_monitor
        list_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(apply_command(slid_cmd_t'(req_ch.cmd),
                                                         req_ch.value));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                response_count++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("response transfer with no command outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  rsp_ch.entry_count, want.entry_count));
                    if (rsp_ch.smallest !== want.smallest)
                        report_mismatch($sformatf("smallest %0d, expected %0d",
                                                  rsp_ch.smallest, want.smallest));
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Run stopped after %0d cycles with %0d commands and %0d responses open.",
                     cycle_count, queued_commands.size(), expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        bit                       filling;
        int                       roll;
        logic signed [DATA_W-1:0] val;
        slid_cmd_t                op;

        // Inputs known from time zero; reset stays asserted while the commands are queued.
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_INSERT;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;

        // Directed part. A delete on the empty list must miss and report a
        // smallest of zero. Then both extremes, zero, minus one and a repeated
        // zero go in, one of the equal zeros is removed, and a value that was
        // never stored is looked for.
        queue_command(CMD_DELETE, 32'sd5, 1'b0);
        queue_command(CMD_INSERT, MOST_POSITIVE, 1'b0);
        queue_command(CMD_INSERT, MOST_NEGATIVE, 1'b0);
        queue_command(CMD_INSERT, 32'sd0, 1'b0);
        queue_command(CMD_INSERT, -32'sd1, 1'b0);
        queue_command(CMD_INSERT, 32'sd0, 1'b0);
        queue_command(CMD_DELETE, 32'sd0, 1'b0);
        queue_command(CMD_DELETE, 32'sd5, 1'b0);
        // Fill to capacity with a second copy of each extreme among the rest.
        for (int i = 0; i < 12; i++)
        begin
            if (i == 3)
                val = MOST_NEGATIVE;
            else if (i == 7)
                val = MOST_POSITIVE;
            else
                val = i * 7 - 40;
            queue_command(CMD_INSERT, val, 1'b0);
        end
        // The list is full now, so this insert must be refused unchanged.
        queue_command(CMD_INSERT, 32'sd42, 1'b0);
        queue_command(CMD_DELETE, MOST_NEGATIVE, 1'b0);
        queue_command(CMD_DELETE, MOST_POSITIVE, 1'b0);

        // Random part: alternating fill and drain phases, so the list keeps
        // passing through full and empty. Deletes mostly name a value that
        // will be held, which makes hits, misses and duplicates all common.
        filling = 1'b1;
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            if (future_contents.size() >= CAPACITY)
                filling = 1'b0;
            else if (future_contents.size() == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            op = (roll < (filling ? 75 : 25)) ? CMD_INSERT : CMD_DELETE;
            roll = $urandom_range(0, 99);
            if (op == CMD_INSERT)
            begin
                if (roll < 35)
                begin
                    val = $signed($urandom_range(0, 12)) - 6;
                end
                else if (roll < 50 && future_contents.size() != 0)
                begin
                    val = future_contents[$urandom_range(0, future_contents.size() - 1)];
                end
                else if (roll < 60)
                begin
                    case ($urandom_range(0, 3))
                        0: val = MOST_NEGATIVE;
                        1: val = MOST_POSITIVE;
                        2: val = MOST_NEGATIVE + 1;
                        default: val = MOST_POSITIVE - 1;
                    endcase
                end
                else
                begin
                    val = $urandom;
                end
            end
            else
            begin
                if (roll < 65 && future_contents.size() != 0)
                    val = future_contents[$urandom_range(0, future_contents.size() - 1)];
                else if (roll < 85)
                    val = $signed($urandom_range(0, 12)) - 6;
                else
                    val = $urandom;
            end
            // Every few hundred commands the sender waits for the block to
            // drain completely before going on.
            queue_command(op, val, (n % 425) == 0);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every command has transferred and every response has
        // been checked, then keep running so that anything stray would show.
        while (queued_commands.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_results.size()));

        $display("Checked %0d responses: %0d inserts, %0d deletes, %0d misses, %0d full refusals.",
                 response_count, status_seen[ST_INSERTED], status_seen[ST_DELETED],
                 status_seen[ST_NOTFOUND], status_seen[ST_FULL]);
        $display("Run took %0d cycles with %0d mismatches.", cycle_count, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/slid_pkg.sv
sv/slid_ifs.sv
sv/slid_cell.sv
sv/sorted_list_insert_delete.sv
sv/slid_checker.sv
bench/sorted_list_insert_delete_test.sv
